// ===== design/rgblab_pkg.sv =====
// ----------------------------------------------------------------------------
// rgblab_pkg
// Shared types, constants and the sRGB transfer table of the RGB to L*a*b*
// converter.
// ----------------------------------------------------------------------------
package rgblab_pkg;

	localparam int LIN_W         = 21;
	localparam int FRAC_BITS_DEF = 8;

	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	typedef logic [LIN_W-1:0] lin_tbl_t [256];

	// matrix rows scaled by two (and by ten for X and Z), plus rounding bias
	localparam longint unsigned X_R2   = 82480;
	localparam longint unsigned X_G2   = 71520;
	localparam longint unsigned X_B2   = 36100;
	localparam longint unsigned X_BIAS = 95047;
	localparam longint unsigned X_DIV  = 2 * X_BIAS;
	localparam longint unsigned Y_R2   = 4252;
	localparam longint unsigned Y_G2   = 14304;
	localparam longint unsigned Y_B2   = 1444;
	localparam longint unsigned Y_BIAS = 10000;
	localparam longint unsigned Y_DIV  = 2 * Y_BIAS;
	localparam longint unsigned Z_R2   = 3860;
	localparam longint unsigned Z_G2   = 23840;
	localparam longint unsigned Z_B2   = 190100;
	localparam longint unsigned Z_BIAS = 108883;
	localparam longint unsigned Z_DIV  = 2 * Z_BIAS;

	localparam int XN_W = 38;
	localparam int YN_W = 35;
	localparam int ZN_W = 38;

	// knee
	localparam longint unsigned KNEE_PROD = 64'd8856 << 20;
	localparam logic [LIN_W-1:0] KNEE_MIN = LIN_W'(KNEE_PROD / 1000000 + 1);
	localparam int              KL_V_W = 14;
	localparam int              KL_NW  = 40;
	localparam longint unsigned KL_MUL = 15574000;
	localparam longint unsigned KL_OFS = (64'd275862 << 20) + 64'd1000000;
	localparam longint unsigned KL_DIV = 2000000;

	// output scaling
	localparam longint unsigned L_MUL   = 116;
	localparam longint unsigned L_OFS   = 64'd16 << 20;
	localparam longint unsigned LB_MUL2 = 18066;
	localparam int              LB_NW   = 29;
	localparam longint unsigned LB_DIV  = 5;
	localparam int              LB_W    = 20;
	localparam longint unsigned A_MUL   = 500;
	localparam longint unsigned B_MUL   = 200;

	function automatic lin_tbl_t build_lin_table();
		lin_tbl_t        tbl;
		longint unsigned c;
		longint unsigned t;
		longint unsigned t40;
		longint unsigned t20;
		longint unsigned r;
		longint unsigned cand;
		longint unsigned p;
		for (int i = 0; i < 256; i++) begin
			c = longint'(i);
			if (c * 100000 <= 1031475) begin
				tbl[i] = LIN_W'((2 * c * 104857600 + 329460) / 658920);
			end else begin
				t   = (2 * ((1000 * c + 14025) << 20) + 269025) / 538050;
				t40 = t * t;
				t20 = (t40 + (64'd1 << 19)) >> 20;
				r   = 0;
				for (int k = 20; k >= 0; k--) begin
					cand = r | (64'd1 << k);
					p    = cand;
					for (int m = 0; m < 4; m++) begin
						p = (p * cand) >> 20;
					end
					if (cand <= (64'd1 << 20) && p <= t20) begin
						r = cand;
					end
				end
				tbl[i] = LIN_W'((t40 * r + (64'd1 << 39)) >> 40);
			end
		end
		return tbl;
	endfunction

	localparam lin_tbl_t LIN_TABLE = build_lin_table();

endpackage

// ===== design/rgblab_cdiv.sv =====
// ----------------------------------------------------------------------------
// rgblab_cdiv
// Three-stage floor division of an unsigned word by a constant: reciprocal
// multiply, remainder, one-step correction.
// ----------------------------------------------------------------------------
module rgblab_cdiv
	import rgblab_pkg::*;
#(
	parameter int              NW  = 38,
	parameter longint unsigned DIV = 190094
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] n,
	input  tag_t          tag_in,
	output logic [NW-1:0] q,
	output tag_t          tag_out
);

	localparam logic [NW:0] POW      = (NW+1)'(1) << NW;
	localparam logic [NW:0] MUL_FULL = POW / (NW+1)'(DIV);
	localparam int          MW       = $clog2(MUL_FULL + (NW+1)'(1));
	localparam logic [MW-1:0] MUL    = MW'(MUL_FULL);
	localparam logic [NW:0] QMAX     = (POW - (NW+1)'(1)) / (NW+1)'(DIV);
	localparam int          QW       = $clog2(QMAX + (NW+1)'(1));
	localparam int          DW       = $clog2(DIV + 1);

	logic [NW+MW-1:0] prod_s1;
	logic [NW-1:0]    n_s1;
	logic [QW-1:0]    q0_s2;
	logic [DW:0]      rem_s2;
	logic [NW-1:0]    q_s3;
	tag_t             tag_s1, tag_s2, tag_s3;

	logic [QW-1:0] q0;
	logic [NW-1:0] qd;
	logic [NW-1:0] rem_full;

	assign q0       = QW'(prod_s1 >> NW);
	assign qd       = NW'(q0) * NW'(DIV);
	assign rem_full = n_s1 - qd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (NW+MW)'(n) * (NW+MW)'(MUL);
			n_s1    <= n;
			q0_s2   <= q0;
			rem_s2  <= (DW+1)'(rem_full);
			q_s3    <= NW'(q0_s2) + NW'(rem_s2 >= (DW+1)'(DIV));
		end
	end

	assign q       = q_s3;
	assign tag_out = tag_s3;

endmodule

// ===== design/rgblab_knee.sv =====
// ----------------------------------------------------------------------------
// rgblab_knee
// CIE knee function in Q20: pipelined cube root one digit a stage, linear
// branch below the threshold.
// ----------------------------------------------------------------------------
module rgblab_knee
	import rgblab_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [LIN_W-1:0] v,
	input  tag_t             tag_in,
	output logic [LIN_W-1:0] f,
	output logic [LIN_W-1:0] v_out,
	output logic             above,
	output tag_t             tag_out
);

	localparam int STEPS = 21;
	localparam int REM_W = LIN_W + 40;
	localparam int SQ_W  = 2 * LIN_W;
	localparam int FL_D  = STEPS - 4;

	logic [LIN_W-1:0] y_s   [STEPS];
	logic [SQ_W-1:0]  y2_s  [STEPS];
	logic [REM_W-1:0] rem_s [STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int S = 3 * (STEPS - 1 - j);
		logic [LIN_W-1:0] y_p, y_d, y_n;
		logic [SQ_W-1:0]  y2_p, y2_d, y2_n;
		logic [REM_W-1:0] rem_p, rem_n;
		logic [SQ_W+1:0]  bsum, bq;
		logic [63:0]      bsh;

		if (j == 0) begin : g_first
			assign y_p   = '0;
			assign y2_p  = '0;
			assign rem_p = {v, 40'd0};
		end else begin : g_next
			assign y_p   = y_s[j-1];
			assign y2_p  = y2_s[j-1];
			assign rem_p = rem_s[j-1];
		end

		always_comb begin
			y_d  = y_p << 1;
			y2_d = y2_p << 2;
			bsum = (SQ_W+2)'(y2_d) + (SQ_W+2)'(y_d);
			bq   = (bsum << 1) + bsum + (SQ_W+2)'(1);
			bsh  = 64'(bq) << S;
			if (64'(rem_p) >= bsh) begin
				rem_n = REM_W'(64'(rem_p) - bsh);
				y2_n  = y2_d + SQ_W'({y_d, 1'b0}) + SQ_W'(1);
				y_n   = y_d + LIN_W'(1);
			end else begin
				rem_n = rem_p;
				y2_n  = y2_d;
				y_n   = y_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				y_s[j]   <= y_n;
				y2_s[j]  <= y2_n;
				rem_s[j] <= rem_n;
			end
		end
	end

	logic [KL_NW-1:0] kl_n_s1;
	logic [KL_NW-1:0] kl_q;
	logic [LIN_W-1:0] fl_d    [FL_D];
	logic [LIN_W-1:0] v_d     [STEPS];
	logic             above_d [STEPS];
	tag_t             tag_d   [STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			kl_n_s1 <= KL_NW'(v[KL_V_W-1:0]) * KL_NW'(KL_MUL) + KL_NW'(KL_OFS);
		end
	end

	rgblab_cdiv #(
		.NW  (KL_NW),
		.DIV (KL_DIV)
	) u_lin_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.n       (kl_n_s1),
		.tag_in  (tag_in),
		.q       (kl_q),
		.tag_out ()
	);

	always_ff @(posedge clk) begin
		if (en) begin
			fl_d[0]    <= kl_q[LIN_W-1:0];
			v_d[0]     <= v;
			above_d[0] <= (v >= KNEE_MIN);
			for (int i = 1; i < FL_D; i++) begin
				fl_d[i] <= fl_d[i-1];
			end
			for (int i = 1; i < STEPS; i++) begin
				v_d[i]     <= v_d[i-1];
				above_d[i] <= above_d[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEPS; i++) begin
				tag_d[i] <= '0;
			end
		end else if (en) begin
			tag_d[0] <= tag_in;
			for (int i = 1; i < STEPS; i++) begin
				tag_d[i] <= tag_d[i-1];
			end
		end
	end

	assign f       = above_d[STEPS-1] ? y_s[STEPS-1] : fl_d[FL_D-1];
	assign v_out   = v_d[STEPS-1];
	assign above   = above_d[STEPS-1];
	assign tag_out = tag_d[STEPS-1];

endmodule

// ===== design/rgb_to_cielab_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_cielab_converter
// sRGB pixel to CIE L*a*b* (D65) in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tdata carries blue, green, red bytes; s_tlast marks
// the last pixel of the image. Output stream m_*: m_tdata of the result
// carries L*, a*, b* with FRAC_BITS fraction bits, saturated; m_tlast
// copies s_tlast of the same pixel.
// The pipeline holds, in order: table lookup, matrix, constant divider,
// cube-root pipeline, scaling, divider for the dark lightness branch,
// and the output register.
// Throughput is one pixel per clock unless stalled; all stages advance together.
// A stalled receiver freezes the whole pipeline; s_tready stays high while
// the output register is empty or being taken, so bubbles still accept.
// Reset clears all valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
module rgb_to_cielab_converter
	import rgblab_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // lightness[14:0], green_red_axis[30:15],
	                               // blue_yellow_axis[46:31], zero[47]
	output logic        m_tlast
);

	localparam int     SH     = 20 - FRAC_BITS;
	localparam int     LMAX_I = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
	localparam logic signed [31:0] HALF = 32'sd1 <<< (SH - 1);
	localparam logic signed [31:0] LMAX = 32'(LMAX_I);
	localparam logic [29:0]        LB_OFS = 30'(10 << SH);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	tag_t             tag_s1, tag_s2;
	logic [LIN_W-1:0] lb_s1, lg_s1, lr_s1;
	logic [XN_W-1:0]  nx_s2;
	logic [YN_W-1:0]  ny_s2;
	logic [ZN_W-1:0]  nz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= '{valid: s_tvalid, last: s_tlast};
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lb_s1 <= LIN_TABLE[s_tdata[7:0]];
			lg_s1 <= LIN_TABLE[s_tdata[15:8]];
			lr_s1 <= LIN_TABLE[s_tdata[23:16]];
			nx_s2 <= XN_W'(lr_s1) * XN_W'(X_R2) + XN_W'(lg_s1) * XN_W'(X_G2)
			       + XN_W'(lb_s1) * XN_W'(X_B2) + XN_W'(X_BIAS);
			ny_s2 <= YN_W'(lr_s1) * YN_W'(Y_R2) + YN_W'(lg_s1) * YN_W'(Y_G2)
			       + YN_W'(lb_s1) * YN_W'(Y_B2) + YN_W'(Y_BIAS);
			nz_s2 <= ZN_W'(lr_s1) * ZN_W'(Z_R2) + ZN_W'(lg_s1) * ZN_W'(Z_G2)
			       + ZN_W'(lb_s1) * ZN_W'(Z_B2) + ZN_W'(Z_BIAS);
		end
	end

	logic [XN_W-1:0] xq;
	logic [YN_W-1:0] yq;
	logic [ZN_W-1:0] zq;
	tag_t            tag_c;

	rgblab_cdiv #(.NW(XN_W), .DIV(X_DIV)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .n(nx_s2), .tag_in(tag_s2),
		.q(xq), .tag_out(tag_c)
	);
	rgblab_cdiv #(.NW(YN_W), .DIV(Y_DIV)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .n(ny_s2), .tag_in(tag_s2),
		.q(yq), .tag_out()
	);
	rgblab_cdiv #(.NW(ZN_W), .DIV(Z_DIV)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .n(nz_s2), .tag_in(tag_s2),
		.q(zq), .tag_out()
	);

	logic [LIN_W-1:0] fx, fy, fz, yk;
	logic             above_y;
	tag_t             tag_k;

	rgblab_knee u_knee_x (
		.clk(clk), .arst_n(arst_n), .en(en), .v(xq[LIN_W-1:0]), .tag_in(tag_c),
		.f(fx), .v_out(), .above(), .tag_out()
	);
	rgblab_knee u_knee_y (
		.clk(clk), .arst_n(arst_n), .en(en), .v(yq[LIN_W-1:0]), .tag_in(tag_c),
		.f(fy), .v_out(yk), .above(above_y), .tag_out(tag_k)
	);
	rgblab_knee u_knee_z (
		.clk(clk), .arst_n(arst_n), .en(en), .v(zq[LIN_W-1:0]), .tag_in(tag_c),
		.f(fz), .v_out(), .above(), .tag_out()
	);

	logic signed [31:0] lhi_c, a_c, b_c;
	logic [29:0]        lbn_c;

	always_comb begin
		lhi_c = ($signed(32'(L_MUL)) * $signed({11'd0, fy}) - $signed(32'(L_OFS))
		      + HALF) >>> SH;
		a_c   = ($signed(32'(A_MUL)) * ($signed({11'd0, fx}) - $signed({11'd0, fy}))
		      + HALF) >>> SH;
		b_c   = ($signed(32'(B_MUL)) * ($signed({11'd0, fy}) - $signed({11'd0, fz}))
		      + HALF) >>> SH;
		lbn_c = (30'(yk[KL_V_W-1:0]) * 30'(LB_MUL2) + LB_OFS) >> (SH + 2);
	end

	tag_t               tag_s3;
	logic signed [31:0] lhi_s3, a_s3, b_s3;
	logic               above_s3;
	logic [LB_NW-1:0]   lbn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_k;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lhi_s3   <= lhi_c;
			a_s3     <= a_c;
			b_s3     <= b_c;
			above_s3 <= above_y;
			lbn_s3   <= lbn_c[LB_NW-1:0];
		end
	end

	logic [LB_NW-1:0] lb_q;
	tag_t             tag_s6;

	rgblab_cdiv #(.NW(LB_NW), .DIV(LB_DIV)) u_div_lb (
		.clk(clk), .arst_n(arst_n), .en(en), .n(lbn_s3), .tag_in(tag_s3),
		.q(lb_q), .tag_out(tag_s6)
	);

	logic signed [31:0] lhi_s6 [3];
	logic signed [31:0] a_s6   [3];
	logic signed [31:0] b_s6   [3];
	logic               above_s6 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			lhi_s6[0]   <= lhi_s3;
			a_s6[0]     <= a_s3;
			b_s6[0]     <= b_s3;
			above_s6[0] <= above_s3;
			for (int i = 1; i < 3; i++) begin
				lhi_s6[i]   <= lhi_s6[i-1];
				a_s6[i]     <= a_s6[i-1];
				b_s6[i]     <= b_s6[i-1];
				above_s6[i] <= above_s6[i-1];
			end
		end
	end

	logic signed [31:0] l_pick;
	logic [14:0]        l_sat;
	logic [15:0]        a_sat, b_sat;

	always_comb begin
		l_pick = above_s6[2] ? lhi_s6[2] : $signed({12'd0, lb_q[LB_W-1:0]});
		if (l_pick < 32'sd0) begin
			l_sat = '0;
		end else if (l_pick > LMAX) begin
			l_sat = LMAX[14:0];
		end else begin
			l_sat = l_pick[14:0];
		end
		if (a_s6[2] > 32'sd32767) begin
			a_sat = 16'h7fff;
		end else if (a_s6[2] < -32'sd32768) begin
			a_sat = 16'h8000;
		end else begin
			a_sat = a_s6[2][15:0];
		end
		if (b_s6[2] > 32'sd32767) begin
			b_sat = 16'h7fff;
		end else if (b_s6[2] < -32'sd32768) begin
			b_sat = 16'h8000;
		end else begin
			b_sat = b_s6[2][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= tag_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {1'b0, b_sat, a_sat, l_sat};
			m_tlast <= tag_s6.last;
		end
	end

`ifndef SYNTHESIS
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output register state");

	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output word changed");

	a_lightness_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[14:0]) <= 32'(LMAX)))
		else $error("lightness above saturation bound");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47] == 1'b0))
		else $error("output pad bit set");
`endif

endmodule
